// ===== src/bs3_pkg.sv =====
`timescale 1ns / 1ps

package bs3_pkg;

  localparam int PIX_W            = 16;
  localparam int CFG_W            = 11;
  localparam int DEF_MAX_SIDE     = 1024;
  localparam int DEF_CHANNEL_BITS = 16;
  localparam int MIN_SIDE         = 2;
  localparam int Q_DEPTH          = 4;

  localparam logic [CFG_W-1:0] SIDE_RESET = CFG_W'(64);

  // operation codes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef struct packed {
    logic             operation;
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;
    logic             frame_last;
  } out_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] b;
  } rgb_t;

  // which neighbours of the output pixel lie inside the image
  typedef struct packed {
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
  } nb_flags_t;

  // one column step handed from front to back
  typedef struct packed {
    rgb_t      pix;
    logic      in_range;
    logic      emit;
    nb_flags_t nb;
    logic      last;
  } cmd_t;

endpackage

// ===== src/bs3_ram.sv =====
`timescale 1ns / 1ps

module bs3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/bs3_queue.sv =====
`timescale 1ns / 1ps

module bs3_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             push;
  logic             pop;

  assign wr_ready = (count != CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = slot[rptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== src/bs3_front.sv =====
`timescale 1ns / 1ps

module bs3_front #(
  parameter int MAX_SIDE     = 1024,
  parameter int CHANNEL_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              pix_valid,
  output logic                              pix_ready,
  input  bs3_pkg::in_item_t                 pix_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bs3_pkg::CFG_W-1:0]         cfg_data,
  output logic                              cmd_valid,
  input  logic                              cmd_ready,
  output bs3_pkg::cmd_t                     cmd,
  output logic [$clog2(MAX_SIDE)-1:0]       cmd_addr
);
  import bs3_pkg::*;

  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int ADDR_W = $clog2(MAX_SIDE);
  localparam logic [PIX_W-1:0] CHAN_MASK = PIX_W'((1 << CHANNEL_BITS) - 1);

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
    logic [SIDE_W-1:0] s;
    if (v < CFG_W'(MIN_SIDE)) begin
      s = SIDE_W'(MIN_SIDE);
    end else if (32'(v) > 32'(MAX_SIDE)) begin
      s = SIDE_W'(MAX_SIDE);
    end else begin
      s = SIDE_W'(v);
    end
    return s;
  endfunction

  logic [SIDE_W-1:0] side;
  logic [SIDE_W-1:0] row;
  logic [SIDE_W-1:0] col;
  logic [SIDE_W-1:0] orow;
  logic [SIDE_W-1:0] ocol;

  logic [SIDE_W-1:0] side_m1;
  logic [SIDE_W-1:0] col_inc;
  logic              is_drain;
  logic              pix_ok;
  logic              drain_ok;
  logic              live;
  logic              emit;
  logic              last;
  logic              acc;

  assign side_m1   = side - SIDE_W'(1);
  assign col_inc   = col + SIDE_W'(1);
  assign is_drain  = (pix_data.operation == OP_DRAIN);
  assign pix_ok    = !is_drain && (row < side);
  // drains are taken only once every pixel of the frame is in
  assign drain_ok  = is_drain && (row >= side) && (col <= side);
  assign live      = pix_ok || drain_ok;
  // first output is due once one row plus one pixel has come in
  assign emit      = (row > SIDE_W'(1)) || ((row == SIDE_W'(1)) && (col != '0));
  assign last      = emit && (orow == side_m1) && (ocol == side_m1);

  assign pix_ready = cmd_ready;
  assign cfg_ready = 1'b1;
  assign acc       = pix_valid && pix_ready;
  assign cmd_valid = acc && live;
  assign cmd_addr  = col[ADDR_W-1:0];

  always_comb begin
    cmd.pix.r       = is_drain ? '0 : (pix_data.red_in & CHAN_MASK);
    cmd.pix.g       = is_drain ? '0 : (pix_data.green_in & CHAN_MASK);
    cmd.pix.b       = is_drain ? '0 : (pix_data.blue_in & CHAN_MASK);
    cmd.in_range    = (col < side);
    cmd.emit        = emit;
    cmd.nb.top_ok   = (orow != '0);
    cmd.nb.bot_ok   = (orow != side_m1);
    cmd.nb.left_ok  = (ocol != '0);
    cmd.nb.right_ok = (ocol != side_m1);
    cmd.last        = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side <= clamp_side(SIDE_RESET);
      row  <= '0;
      col  <= '0;
      orow <= '0;
      ocol <= '0;
    end else if (cfg_valid && cfg_ready) begin
      side <= clamp_side(cfg_data);
      row  <= '0;
      col  <= '0;
      orow <= '0;
      ocol <= '0;
    end else if (cmd_valid) begin
      if (last) begin
        row  <= '0;
        col  <= '0;
        orow <= '0;
        ocol <= '0;
      end else begin
        if (!is_drain && (col_inc == side)) begin
          col <= '0;
          row <= row + SIDE_W'(1);
        end else begin
          col <= col_inc;
        end
        if (emit) begin
          if (ocol == side_m1) begin
            ocol <= '0;
            orow <= orow + SIDE_W'(1);
          end else begin
            ocol <= ocol + SIDE_W'(1);
          end
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_row_bound: assert property (@(posedge clk) disable iff (rst) row <= side)
    else $error("input row past image side");
  a_ocol_bound: assert property (@(posedge clk) disable iff (rst) ocol < side)
    else $error("output column past image side");
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
      cmd_valid && cmd.last && !cfg_valid |=> (row == '0) && (col == '0) && (orow == '0))
    else $error("frame end did not clear counters");
  a_range_drain: assert property (@(posedge clk) disable iff (rst)
      cmd_valid && !cmd.in_range |-> is_drain)
    else $error("pixel outside line store range");
`endif

endmodule

// ===== src/bs3_back.sv =====
`timescale 1ns / 1ps

module bs3_back #(
  parameter int MAX_SIDE     = 1024,
  parameter int CHANNEL_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  bs3_pkg::cmd_t                 q_cmd,
  input  logic [$clog2(MAX_SIDE)-1:0]   q_addr,
  output logic                          res_valid,
  input  logic                          res_ready,
  output bs3_pkg::out_item_t            res_data
);
  import bs3_pkg::*;

  localparam int ADDR_W = $clog2(MAX_SIDE);
  localparam int CB     = CHANNEL_BITS;
  localparam int LW     = 3 * CB;
  localparam int CS_W   = CB + 2;
  localparam int SUM_W  = CB + 4;
  localparam int K      = SUM_W + 4;
  localparam int M_W    = K - 1;
  localparam int P_W    = SUM_W + M_W;
  // reciprocals rounded up; exact for every sum below 2**SUM_W
  localparam logic [M_W-1:0] M9 = M_W'(((1 << K) + 8) / 9);
  localparam logic [M_W-1:0] M6 = M_W'(((1 << K) + 5) / 6);
  localparam logic [M_W-1:0] M4 = M_W'(1 << (K - 2));

  typedef enum logic [1:0] {DIV4, DIV6, DIV9} div_sel_t;

  logic             en;
  logic             pop;

  logic             s1_valid;
  cmd_t             s1_cmd;
  logic [ADDR_W-1:0] s1_addr;
  logic [LW-1:0]    rd_older;
  logic [LW-1:0]    rd_newer;
  logic [LW-1:0]    pix_packed;
  logic             re;
  logic             we;

  // window [column][row][channel], column 1 is the center
  logic [CB-1:0]    win [3][3][3];

  logic             v2;
  nb_flags_t        nb2;
  logic             last2;
  logic [CS_W-1:0]  colsum [3][3];

  logic             v3;
  nb_flags_t        nb3;
  logic             last3;
  logic [CS_W-1:0]  cs3 [3][3];
  logic [SUM_W-1:0] total [3];
  div_sel_t         sel;
  logic             rows3;
  logic             cols3;

  logic             v4;
  logic             last4;
  logic [SUM_W-1:0] tot4 [3];
  div_sel_t         sel4;
  logic [M_W-1:0]   recip;

  logic             v5;
  logic             last5;
  logic [P_W-1:0]   prod5 [3];

  assign en      = !res_valid || res_ready;
  assign q_ready = en;
  assign pop     = q_valid && en;

  assign re         = pop && q_cmd.in_range;
  assign we         = en && s1_valid && s1_cmd.in_range;
  assign pix_packed = {s1_cmd.pix.b[CB-1:0], s1_cmd.pix.g[CB-1:0], s1_cmd.pix.r[CB-1:0]};

  // older row takes the newer row's old entry, newer row takes this pixel
  bs3_ram #(.WIDTH(LW), .DEPTH(MAX_SIDE)) u_older (
    .clk   (clk),
    .we    (we),
    .waddr (s1_addr),
    .wdata (rd_newer),
    .re    (re),
    .raddr (q_addr),
    .rdata (rd_older)
  );

  bs3_ram #(.WIDTH(LW), .DEPTH(MAX_SIDE)) u_newer (
    .clk   (clk),
    .we    (we),
    .waddr (s1_addr),
    .wdata (pix_packed),
    .re    (re),
    .raddr (q_addr),
    .rdata (rd_newer)
  );

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_cmd  <= q_cmd;
      s1_addr <= q_addr;
    end
    if (en && s1_valid) begin
      win[0] <= win[1];
      win[1] <= win[2];
      for (int ch = 0; ch < 3; ch++) begin
        win[2][0][ch] <= rd_older[ch*CB +: CB];
        win[2][1][ch] <= rd_newer[ch*CB +: CB];
        win[2][2][ch] <= pix_packed[ch*CB +: CB];
      end
    end
  end

  // column sums over the rows inside the image
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int ch = 0; ch < 3; ch++) begin
        colsum[c][ch] = (nb2.top_ok ? CS_W'(win[c][0][ch]) : '0)
                      + CS_W'(win[c][1][ch])
                      + (nb2.bot_ok ? CS_W'(win[c][2][ch]) : '0);
      end
    end
  end

  assign rows3 = nb3.top_ok && nb3.bot_ok;
  assign cols3 = nb3.left_ok && nb3.right_ok;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      total[ch] = (nb3.left_ok ? SUM_W'(cs3[0][ch]) : '0)
                + SUM_W'(cs3[1][ch])
                + (nb3.right_ok ? SUM_W'(cs3[2][ch]) : '0);
    end
    if (rows3 && cols3) begin
      sel = DIV9;
    end else if (rows3 || cols3) begin
      sel = DIV6;
    end else begin
      sel = DIV4;
    end
  end

  always_comb begin
    unique case (sel4)
      DIV9:    recip = M9;
      DIV6:    recip = M6;
      DIV4:    recip = M4;
      default: recip = M4;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nb2   <= s1_cmd.nb;
      last2 <= s1_cmd.last;
      nb3   <= nb2;
      last3 <= last2;
      cs3   <= colsum;
      last4 <= last3;
      tot4  <= total;
      sel4  <= sel;
      last5 <= last4;
      for (int ch = 0; ch < 3; ch++) begin
        prod5[ch] <= P_W'(tot4[ch]) * P_W'(recip);
      end
      res_data.red_out    <= PIX_W'(prod5[0][K +: CB]);
      res_data.green_out  <= PIX_W'(prod5[1][K +: CB]);
      res_data.blue_out   <= PIX_W'(prod5[2][K +: CB]);
      res_data.frame_last <= last5;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      res_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= q_valid;
      v2        <= s1_valid && s1_cmd.emit;
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      res_valid <= v5;
    end
  end

`ifndef SYNTHESIS
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
      !(we && re && (s1_addr == q_addr)))
    else $error("line store read and write hit one column");
  a_last_has_result: assert property (@(posedge clk) disable iff (rst)
      en && s1_valid && s1_cmd.last |-> s1_cmd.emit && !s1_cmd.nb.bot_ok && !s1_cmd.nb.right_ok)
    else $error("frame end on a pixel that is not the corner");
`endif

endmodule

// ===== src/box_smooth_3x3_rgb.sv =====
`timescale 1ns / 1ps

// Channel  Signals                          Carries
// -------  -------------------------------  ----------------------------------
// pix      pix_valid pix_ready pix_data     input item: operation, red/green/blue
// res      res_valid res_ready res_data     result item: averaged rgb, frame_last
// cfg      cfg_valid cfg_ready cfg_data     image_side write, always ready
//
// One item per clock while res is ready; each line store takes one column read and one
// write a cycle. Once the item that completes its window leaves the queue, its result
// passes line store read, window, column sums, totals, multiply, output reg. Results trail
// pixels by a row plus one. Reset (rst, synchronous) clears counters and valid bits;
// line stores stay undefined, their unwritten entries never reach a result.
// A stalled res side freezes the back pipe; the 4-entry queue takes items until full.

module box_smooth_3x3_rgb #(
  parameter int MAX_SIDE     = bs3_pkg::DEF_MAX_SIDE,
  parameter int CHANNEL_BITS = bs3_pkg::DEF_CHANNEL_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       pix_valid,
  output logic                       pix_ready,
  input  bs3_pkg::in_item_t          pix_data,
  output logic                       res_valid,
  input  logic                       res_ready,
  output bs3_pkg::out_item_t         res_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [bs3_pkg::CFG_W-1:0]  cfg_data
);
  import bs3_pkg::*;

  localparam int ADDR_W = $clog2(MAX_SIDE);
  localparam int CMD_W  = $bits(cmd_t);
  localparam int QW     = CMD_W + ADDR_W;

  // front side: position tracking, edge flags, drop of ignored items
  logic              f_valid;
  logic              f_ready;
  cmd_t              f_cmd;
  logic [ADDR_W-1:0] f_addr;

  // back side: head of the queue
  logic              b_valid;
  logic              b_ready;
  logic [QW-1:0]     b_word;
  cmd_t              b_cmd;
  logic [ADDR_W-1:0] b_addr;

  bs3_front #(.MAX_SIDE(MAX_SIDE), .CHANNEL_BITS(CHANNEL_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix_data  (pix_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd),
    .cmd_addr  (f_addr)
  );

  // short queue so the front keeps accepting while results back up
  bs3_queue #(.WIDTH(QW), .DEPTH(Q_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  ({f_cmd, f_addr}),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (b_word)
  );

  assign b_cmd  = cmd_t'(b_word[QW-1 -: CMD_W]);
  assign b_addr = b_word[ADDR_W-1:0];

  // line stores, 3x3 window, sum and divide pipe, output register
  bs3_back #(.MAX_SIDE(MAX_SIDE), .CHANNEL_BITS(CHANNEL_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (b_valid),
    .q_ready   (b_ready),
    .q_cmd     (b_cmd),
    .q_addr    (b_addr),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

endmodule
